### rtl/hcbp_pkg.sv
// shared constants and types for the prefix-code bit packer
package hcbp_pkg;

   // item field widths
   localparam int MODE_W      = 2;
   localparam int SYMBOL_W    = 8;
   localparam int LEN_W       = 6;
   localparam int CODE_WORD_W = 32;
   localparam int BYTE_BITS   = 8;
   localparam int PAD_W       = 3;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

   // code table sizing
   localparam int MAX_CODE_LEN   = 32;
   localparam int SYMBOL_COUNT   = 256;
   localparam int ADDR_W         = $clog2(SYMBOL_COUNT);
   localparam int ENTRY_W        = LEN_W + CODE_WORD_W;
   localparam int CODE_LEN_LIMIT = (MAX_CODE_LEN < CODE_WORD_W) ? MAX_CODE_LEN : CODE_WORD_W;

   // bit accumulator and merge sizing
   localparam int ACC_W       = BYTE_BITS - 1;
   localparam int PEND_W      = $clog2(BYTE_BITS);
   localparam int ACC_TOTAL_W = ACC_W + CODE_WORD_W;
   localparam int ALIGN_W     = ACC_TOTAL_W + 1;
   localparam int CNT_W       = $clog2(ALIGN_W + 1);
   localparam int MAX_BYTES   = ACC_TOTAL_W / BYTE_BITS;
   localparam int GRP_W       = $clog2(MAX_BYTES + 1);

   typedef logic [BYTE_BITS-1:0] byte_type;

endpackage

### rtl/hcbp_ram.sv
// generic single-port-write, registered-read ram
module hcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/huffman_code_bit_packer_core.sv
// prefix-code bit packer top level: code table, bit merge and byte output queue
//
// Usage: req_ carries one item per accepted cycle (req_valid high, req_stall low).
// A load item writes one symbol's code and length into the code table; it
// produces no output. An encode item looks up its symbol, appends the code
// bits MSB first to the pending bits and returns every full byte on rsp_.
// A flush item returns the pending bits left-aligned in one zero-padded byte
// (rsp_pad_bits gives the padding) and clears them; with nothing pending it
// returns nothing. rsp_last_of_run marks the final byte of each item.
// An item and its table read are registered into the merge stage; its merged
// bytes are registered into the byte queue. One item passes per cycle while
// rsp_stall is low and each item yields at most one byte; the byte queue
// drains one byte per unstalled cycle, so an item yielding k bytes holds the
// next emitting item until its last byte is taken. Loads and silent items
// pass every cycle unless an item ahead of them waits. When the receiver holds
// rsp_stall high the current byte stays on the port, the merge stage fills
// and then req_stall rises. Reset clears the pending bits and the byte queue;
// the code table content is kept and must be loaded before a symbol is encoded.
module huffman_code_bit_packer_core
   import hcbp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [SYMBOL_W-1:0]    req_symbol,
   input  logic [LEN_W-1:0]       req_code_length,
   input  logic [CODE_WORD_W-1:0] req_code_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BYTE_BITS-1:0]   rsp_packed_byte,
   output logic [PAD_W-1:0]       rsp_pad_bits,
   output logic                   rsp_last_of_run
);

   // merge stage registers
   logic              stage_valid_ff, stage_valid_in;
   logic [MODE_W-1:0] stage_mode_ff, stage_mode_in;
   logic              stage_sym_ok_ff, stage_sym_ok_in;

   // pending bit state
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PEND_W-1:0] pend_ff, pend_in;

   // output byte queue
   logic              grp_valid_ff, grp_valid_in;
   logic [GRP_W-1:0]  grp_left_ff, grp_left_in;
   logic [PAD_W-1:0]  grp_pad_ff, grp_pad_in;
   byte_type          grp_bytes_ff [MAX_BYTES];
   byte_type          grp_bytes_in [MAX_BYTES];

   // input side
   logic                   req_accept;
   logic                   req_sym_ok;
   logic [LEN_W-1:0]       load_len;
   logic [LEN_W:0]         mask_shift;
   logic [CODE_WORD_W-1:0] load_mask;
   logic [ENTRY_W-1:0]     wr_entry;
   logic [ENTRY_W-1:0]     rd_entry;

   // merge logic
   logic                   do_encode;
   logic                   do_flush;
   logic [LEN_W-1:0]       e_len;
   logic [CODE_WORD_W-1:0] e_word;
   logic [ACC_TOTAL_W-1:0] acc_total;
   logic [CNT_W-1:0]       bit_cnt;
   logic [CNT_W-1:0]       align_shift;
   logic [ALIGN_W-1:0]     aligned;
   logic [GRP_W-1:0]       enc_nbytes;
   logic [PEND_W-1:0]      enc_pend;
   logic [ACC_W-1:0]       enc_acc_mask;
   logic [PEND_W:0]        flush_pad;
   byte_type               flush_byte;
   logic                   stage_emit;
   logic                   stage_move;
   logic                   grp_take;
   logic                   grp_free;

   // input handshake and symbol range check
   assign req_sym_ok = {1'b0, req_symbol} < (SYMBOL_W+1)'(SYMBOL_COUNT);
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = stage_valid_ff && !stage_move;

   // load entry: saturate the length and drop stray code bits
   assign load_len   = (req_code_length > LEN_W'(CODE_LEN_LIMIT)) ?
                       LEN_W'(CODE_LEN_LIMIT) : req_code_length;
   assign mask_shift = (LEN_W+1)'(CODE_WORD_W) - {1'b0, load_len};
   assign load_mask  = (load_len == '0) ? '0 : ({CODE_WORD_W{1'b1}} >> mask_shift);
   assign wr_entry   = {load_len, req_code_word & load_mask};

   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_code_table (
      .clock   (clock),
      .wr_en   (req_accept && (req_mode == MODE_LOAD) && req_sym_ok),
      .wr_addr (req_symbol[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (req_accept && (req_mode == MODE_ENCODE)),
      .rd_addr (req_symbol[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   // merge the looked-up code with the pending bits
   assign do_encode = (stage_mode_ff == MODE_ENCODE) && stage_sym_ok_ff;
   assign do_flush  = (stage_mode_ff == MODE_FLUSH);
   assign e_len     = do_encode ? rd_entry[ENTRY_W-1 -: LEN_W] : '0;
   assign e_word    = do_encode ? rd_entry[CODE_WORD_W-1:0] : '0;

   assign acc_total   = ({{CODE_WORD_W{1'b0}}, acc_ff} << e_len) | {{ACC_W{1'b0}}, e_word};
   assign bit_cnt     = CNT_W'(pend_ff) + CNT_W'(e_len);
   assign align_shift = CNT_W'(ALIGN_W) - bit_cnt;
   assign aligned     = {1'b0, acc_total} << align_shift;
   assign enc_nbytes  = GRP_W'(bit_cnt >> PEND_W);
   assign enc_pend    = bit_cnt[PEND_W-1:0];
   assign enc_acc_mask = {ACC_W{1'b1}} >> (PEND_W'(ACC_W) - enc_pend);

   // flush byte: pending bits left-aligned, zero padded
   assign flush_pad  = (PEND_W+1)'(BYTE_BITS) - {1'b0, pend_ff};
   assign flush_byte = BYTE_BITS'({1'b0, acc_ff} << flush_pad);

   // stage advance: silent items never wait for the byte queue
   assign stage_emit = (do_encode && (enc_nbytes != '0)) || (do_flush && (pend_ff != '0));
   assign grp_take   = grp_valid_ff && !rsp_stall;
   assign grp_free   = !grp_valid_ff || (grp_take && (grp_left_ff == GRP_W'(1)));
   assign stage_move = stage_valid_ff && (!stage_emit || grp_free);

   // next state for merge stage and pending bits
   always_comb begin
      stage_valid_in  = stage_valid_ff;
      stage_mode_in   = stage_mode_ff;
      stage_sym_ok_in = stage_sym_ok_ff;
      acc_in          = acc_ff;
      pend_in         = pend_ff;
      if (stage_move) begin
         stage_valid_in = 1'b0;
         if (do_flush) begin
            acc_in  = '0;
            pend_in = '0;
         end else if (do_encode) begin
            acc_in  = acc_total[ACC_W-1:0] & enc_acc_mask;
            pend_in = enc_pend;
         end
      end
      if (req_accept) begin
         stage_valid_in  = 1'b1;
         stage_mode_in   = req_mode;
         stage_sym_ok_in = req_sym_ok;
      end
   end

   // next state for the byte queue
   always_comb begin
      grp_valid_in = grp_valid_ff;
      grp_left_in  = grp_left_ff;
      grp_pad_in   = grp_pad_ff;
      for (int k = 0; k < MAX_BYTES; k++) begin
         grp_bytes_in[k] = grp_bytes_ff[k];
      end
      if (stage_move && stage_emit) begin
         grp_valid_in = 1'b1;
         if (do_flush) begin
            grp_left_in     = GRP_W'(1);
            grp_pad_in      = flush_pad[PAD_W-1:0];
            grp_bytes_in[0] = flush_byte;
         end else begin
            grp_left_in = enc_nbytes;
            grp_pad_in  = '0;
            for (int k = 0; k < MAX_BYTES; k++) begin
               grp_bytes_in[k] = aligned[ALIGN_W-1-k*BYTE_BITS -: BYTE_BITS];
            end
         end
      end else if (grp_take) begin
         grp_valid_in = (grp_left_ff != GRP_W'(1));
         grp_left_in  = grp_left_ff - GRP_W'(1);
         for (int k = 0; k < MAX_BYTES - 1; k++) begin
            grp_bytes_in[k] = grp_bytes_ff[k+1];
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         acc_ff         <= '0;
         pend_ff        <= '0;
         grp_valid_ff   <= 1'b0;
         grp_left_ff    <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         acc_ff         <= acc_in;
         pend_ff        <= pend_in;
         grp_valid_ff   <= grp_valid_in;
         grp_left_ff    <= grp_left_in;
      end
      stage_mode_ff   <= stage_mode_in;
      stage_sym_ok_ff <= stage_sym_ok_in;
      grp_pad_ff      <= grp_pad_in;
      for (int k = 0; k < MAX_BYTES; k++) begin
         grp_bytes_ff[k] <= grp_bytes_in[k];
      end
   end

   // result port
   assign rsp_valid       = grp_valid_ff;
   assign rsp_packed_byte = grp_bytes_ff[0];
   assign rsp_pad_bits    = grp_pad_ff;
   assign rsp_last_of_run = (grp_left_ff == GRP_W'(1));

endmodule

### sim/tb_huffman_code_bit_packer_core.sv
// self-checking testbench for the prefix-code bit packer core
`timescale 1ns / 100ps

module tb_huffman_code_bit_packer_core
   import hcbp_pkg::*;
;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS     = 500;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_AT     = 120;
   localparam int DRAIN_CYCLES     = 12;
   localparam int RUN_LIMIT_NS     = 5_000_000;

   // one output byte as the block should present it
   typedef struct packed {
      byte_type         data;
      logic [PAD_W-1:0] pad;
      logic             last;
   } packed_out_type;

   // predictor: code table, pending bits and the queue of bytes still owed
   class packed_byte_model;
      logic [CODE_WORD_W-1:0] code_bits [SYMBOL_COUNT];
      int unsigned            code_len [SYMBOL_COUNT];
      logic [ACC_W-1:0]       pend_bits;
      int unsigned            pend_cnt;
      packed_out_type         expected_bytes [$];
      int unsigned            errors;

      function new();
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            code_bits[i] = '0;
            code_len[i]  = 0;
         end
         pend_bits = '0;
         pend_cnt  = 0;
         errors    = 0;
      endfunction

      // work out the bytes that one accepted item owes
      function void absorb_item(logic [MODE_W-1:0] mode, logic [SYMBOL_W-1:0] sym,
                                logic [LEN_W-1:0] len, logic [CODE_WORD_W-1:0] word);
         int unsigned l;
         int unsigned cnt;
         logic [63:0] mask;
         logic [63:0] merged;
         packed_out_type ob;
         case (mode)
            MODE_LOAD: begin
               l = len;
               if (l > CODE_LEN_LIMIT) l = CODE_LEN_LIMIT;
               mask = (l == 0) ? 64'd0 : ((64'd1 << l) - 64'd1);
               code_len[sym]  = l;
               code_bits[sym] = word & mask[CODE_WORD_W-1:0];
            end
            MODE_ENCODE: begin
               l = code_len[sym];
               if (l != 0) begin
                  merged = ({57'd0, pend_bits} << l) | {32'd0, code_bits[sym]};
                  cnt = pend_cnt + l;
                  while (cnt >= BYTE_BITS) begin
                     ob.data = BYTE_BITS'(merged >> (cnt - BYTE_BITS));
                     cnt = cnt - BYTE_BITS;
                     ob.pad  = '0;
                     ob.last = (cnt < BYTE_BITS);
                     expected_bytes.push_back(ob);
                  end
                  pend_cnt  = cnt;
                  mask      = (64'd1 << cnt) - 64'd1;
                  pend_bits = ACC_W'(merged & mask);
               end
            end
            MODE_FLUSH: begin
               if (pend_cnt != 0) begin
                  ob.pad  = PAD_W'(BYTE_BITS - pend_cnt);
                  ob.data = {1'b0, pend_bits} << ob.pad;
                  ob.last = 1'b1;
                  expected_bytes.push_back(ob);
               end
               pend_bits = '0;
               pend_cnt  = 0;
            end
            default: ;
         endcase
      endfunction

      // compare one accepted byte with the oldest one owed
      function void compare_byte(byte_type data, logic [PAD_W-1:0] pad, logic last);
         packed_out_type ob;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte, actual data %02h pad %0d last %0b",
                     $time, data, pad, last);
            errors++;
            return;
         end
         ob = expected_bytes.pop_front();
         if (data !== ob.data) begin
            $display("%0t: packed_byte mismatch, expected %02h actual %02h",
                     $time, ob.data, data);
            errors++;
         end
         if (pad !== ob.pad) begin
            $display("%0t: pad_bits mismatch, expected %0d actual %0d", $time, ob.pad, pad);
            errors++;
         end
         if (last !== ob.last) begin
            $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                     $time, ob.last, last);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return expected_bytes.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [MODE_W-1:0]      req_mode;
   logic [SYMBOL_W-1:0]    req_symbol;
   logic [LEN_W-1:0]       req_code_length;
   logic [CODE_WORD_W-1:0] req_code_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [BYTE_BITS-1:0]   rsp_packed_byte;
   logic [PAD_W-1:0]       rsp_pad_bits;
   logic                   rsp_last_of_run;

   packed_byte_model byte_model = new();

   // symbols whose table entry has been written, so encodes never read junk
   bit loaded [SYMBOL_COUNT];
   int loaded_syms [$];

   // quiet: no gaps on either side; long_hold: receiver holds off for a while
   bit quiet;
   bit long_hold;

   huffman_code_bit_packer_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_symbol      (req_symbol),
      .req_code_length (req_code_length),
      .req_code_word   (req_code_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_pad_bits    (rsp_pad_bits),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // clock generation
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // code length for a random load: mostly short, some zero, a few overlong
   function automatic logic [LEN_W-1:0] pick_code_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 70) return LEN_W'($urandom_range(1, 10));
      if (r < 92) return LEN_W'($urandom_range(11, 32));
      return LEN_W'($urandom_range(33, 63));
   endfunction

   // offer one item after a random gap and hold it until accepted
   task automatic push_packer_item(logic [MODE_W-1:0] mode, logic [SYMBOL_W-1:0] sym,
                                   logic [LEN_W-1:0] len, logic [CODE_WORD_W-1:0] word);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_symbol      <= sym;
      req_code_length <= len;
      req_code_word   <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      byte_model.absorb_item(mode, sym, len, word);
      if (mode == MODE_LOAD && !loaded[sym]) begin
         loaded[sym] = 1'b1;
         loaded_syms.push_back(int'(sym));
      end
   endtask

   task automatic encode_random_symbol();
      logic [SYMBOL_W-1:0] sym;
      sym = SYMBOL_W'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
      push_packer_item(MODE_ENCODE, sym, LEN_W'($urandom_range(0, 63)), $urandom());
   endtask

   // result side: check every accepted byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         byte_model.compare_byte(rsp_packed_byte, rsp_pad_bits, rsp_last_of_run);
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pick_gap() + 1) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("*** FAILED ***");
      $finish;
   end

   // stimulus
   initial begin
      int sent;
      int r;
      bit hold_asked;
      logic [SYMBOL_W-1:0] sym;

      quiet           = 1'b0;
      long_hold       = 1'b0;
      hold_asked      = 1'b0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= MODE_ENCODE;
      req_symbol      <= '0;
      req_code_length <= '0;
      req_code_word   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty flush, length extremes, stray bits, unused mode
      push_packer_item(MODE_FLUSH,  8'd0,   6'd0,  32'h0);
      push_packer_item(MODE_LOAD,   8'd0,   6'd32, 32'hFFFF_FFFF);
      push_packer_item(MODE_LOAD,   8'd255, 6'd1,  32'hFFFF_FFFF);
      push_packer_item(MODE_LOAD,   8'd1,   6'd0,  32'hDEAD_BEEF);
      push_packer_item(MODE_LOAD,   8'd2,   6'd63, 32'h1234_5678);
      push_packer_item(MODE_LOAD,   8'd3,   6'd33, 32'hA5A5_A5A5);
      push_packer_item(MODE_LOAD,   8'd4,   6'd8,  32'h0000_00C3);
      push_packer_item(MODE_LOAD,   8'd5,   6'd7,  32'hFFFF_FF2A);
      push_packer_item(MODE_ENCODE, 8'd255, 6'd0,  32'h0);
      push_packer_item(MODE_ENCODE, 8'd0,   6'd0,  32'h0);
      push_packer_item(MODE_ENCODE, 8'd1,   6'd0,  32'h0);
      push_packer_item(MODE_FLUSH,  8'd0,   6'd0,  32'h0);
      push_packer_item(MODE_FLUSH,  8'hFF,  6'h3F, 32'hFFFF_FFFF);
      push_packer_item(MODE_UNUSED, 8'hFF,  6'h3F, 32'hFFFF_FFFF);
      push_packer_item(MODE_ENCODE, 8'd4,   6'h3F, 32'hFFFF_FFFF);
      push_packer_item(MODE_ENCODE, 8'd5,   6'd0,  32'h0);
      push_packer_item(MODE_ENCODE, 8'd2,   6'd0,  32'h0);
      push_packer_item(MODE_FLUSH,  8'd0,   6'd0,  32'h0);
      // load followed by an encode of the same entry
      push_packer_item(MODE_LOAD,   8'd6,   6'd3,  32'h0000_0005);
      push_packer_item(MODE_ENCODE, 8'd6,   6'd0,  32'h0);
      push_packer_item(MODE_LOAD,   8'd6,   6'd12, 32'hFFFF_FABC);
      push_packer_item(MODE_ENCODE, 8'd6,   6'd0,  32'h0);
      push_packer_item(MODE_ENCODE, 8'd3,   6'd0,  32'h0);
      push_packer_item(MODE_FLUSH,  8'd0,   6'd0,  32'h0);

      // random: mostly encodes of loaded symbols, with reloads and flushes
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= LONG_HOLD_AT && !hold_asked) begin
            long_hold  = 1'b1;
            hold_asked = 1'b1;
         end
         quiet = (sent >= 250 && sent < 330);
         r = $urandom_range(0, 99);
         if (r < 12) begin
            sym = SYMBOL_W'($urandom_range(0, SYMBOL_COUNT - 1));
            push_packer_item(MODE_LOAD, sym, pick_code_length(), $urandom());
            sent++;
            if ($urandom_range(0, 2) == 0) begin
               push_packer_item(MODE_ENCODE, sym, LEN_W'($urandom_range(0, 63)),
                                $urandom());
               sent++;
            end
         end else if (r < 82) begin
            encode_random_symbol();
            sent++;
         end else if (r < 96) begin
            push_packer_item(MODE_FLUSH, SYMBOL_W'($urandom_range(0, 255)),
                             LEN_W'($urandom_range(0, 63)), $urandom());
            sent++;
         end else begin
            push_packer_item(MODE_UNUSED, SYMBOL_W'($urandom_range(0, 255)),
                             LEN_W'($urandom_range(0, 63)), $urandom());
         end
      end
      push_packer_item(MODE_FLUSH, 8'd0, 6'd0, 32'h0);
      req_valid <= 1'b0;
      quiet = 1'b0;

      // drain, then give the pipeline time to show any stray byte
      while (byte_model.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (byte_model.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
